/* hdl/gfd_pkg.sv */
// Package for the golden ratio floor and digit unit.
// Holds the default operand width; no dependencies.
package gfd_pkg;

    localparam int unsigned DEF_QBITS = 60;

endpackage

/* hdl/golden_ratio_floor_digit_unit.sv */
// Exact floor(q*phi) and golden base-4 digit, fully pipelined.
// Depends on gfd_pkg.
//
// Usage
//   Input channel: i_in_valid / o_in_ready carry operand i_q. Output channel:
//   o_out_valid / i_out_ready carry o_floor_phi_q = floor(q*phi) and
//   o_base4_digit = floor(4q*phi) - 4*floor(q*phi).
//   Both roots sqrt(5q^2) and sqrt(80q^2) run as digit-by-digit pipelines, one
//   root digit per stage (QBITS+4 stages), after three stages that form 5q^2
//   from narrow partial products, and before one stage of final adds.
//   An operand passes the three product stages, the root stages, the final-add
//   stage and the output register in order. Throughput: one transaction per
//   cycle, sustained while the receiver keeps i_out_ready high.
//   Reset clears all valid bits; payload registers are not reset.
//   When the receiver stalls, the result is held on the output register and a
//   skid register takes one more result from the pipeline; only then does
//   o_in_ready fall and the whole pipeline freeze. Nothing is dropped or
//   repeated across a stall.
module golden_ratio_floor_digit_unit #(
    parameter int unsigned QBITS = gfd_pkg::DEF_QBITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [QBITS-1:0] i_q,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [QBITS:0]   o_floor_phi_q,
    output logic [1:0]       o_base4_digit
);
    import gfd_pkg::*;

    localparam int unsigned H      = (QBITS + 1) / 2;
    localparam int unsigned LB     = QBITS - H;
    localparam int unsigned RSTEPS = QBITS + 4;
    localparam int unsigned RW     = 2 * QBITS + 8;
    localparam int unsigned RMW    = RSTEPS + 2;
    localparam int unsigned NST    = RSTEPS + 4;

    logic             adv;
    logic             pv;

    logic             r_v  [0:NST-1];
    logic [QBITS-1:0] r_qd [0:NST-2];

    logic [2*H-1:0]   r_aa;
    logic [QBITS-1:0] r_ab;
    logic [2*LB-1:0]  r_bb;
    logic [2*H-1:0]   n_aa;
    logic [QBITS-1:0] n_ab;
    logic [2*LB-1:0]  n_bb;

    logic [2*QBITS-1:0] r_sq;
    logic [2*QBITS-1:0] n_sq;
    logic [RW-1:0]      n_n;

    logic [RW-1:0]     r_op  [0:1][0:RSTEPS-1];
    logic [RMW-1:0]    r_rem [0:1][0:RSTEPS];
    logic [RSTEPS-1:0] r_rt  [0:1][0:RSTEPS];
    logic [RW-1:0]     n_op  [0:1][1:RSTEPS-1];
    logic [RMW-1:0]    n_rem [0:1][1:RSTEPS];
    logic [RSTEPS-1:0] n_rt  [0:1][1:RSTEPS];

    logic [QBITS+4:0] n_s1;
    logic [2:0]       n_s4;
    logic [QBITS:0]   r_ff;
    logic [1:0]       r_fd;

    logic             r_ov;
    logic [QBITS:0]   r_of;
    logic [1:0]       r_od;
    logic             r_sv;
    logic [QBITS:0]   r_sf;
    logic [1:0]       r_sd;

    assign adv        = !r_sv;
    assign pv         = r_v[NST-1] && adv;
    assign o_in_ready = adv;

    // partial products of q*q
    assign n_aa = {{H{1'b0}}, i_q[H-1:0]} * {{H{1'b0}}, i_q[H-1:0]};
    assign n_ab = {{LB{1'b0}}, i_q[H-1:0]} * {{H{1'b0}}, i_q[QBITS-1:H]};
    assign n_bb = {{LB{1'b0}}, i_q[QBITS-1:H]} * {{LB{1'b0}}, i_q[QBITS-1:H]};

    assign n_sq = {r_bb, r_aa} + {{(LB-1){1'b0}}, r_ab, {(H+1){1'b0}}};
    assign n_n  = {8'b0, r_sq} + {6'b0, r_sq, 2'b00};

    // one root digit per stage
    always_comb begin
        logic [RMW-1:0] c_r;
        logic [RMW-1:0] c_t;
        logic [RMW:0]   c_d;
        for (int j = 0; j < 2; j++) begin
            for (int s = 1; s <= RSTEPS; s++) begin
                c_r = {r_rem[j][s-1][RMW-3:0], r_op[j][s-1][RW-1:RW-2]};
                c_t = {r_rt[j][s-1], 2'b01};
                c_d = {1'b0, c_r} - {1'b0, c_t};
                n_rem[j][s] = c_d[RMW] ? c_r : c_d[RMW-1:0];
                n_rt[j][s]  = {r_rt[j][s-1][RSTEPS-2:0], !c_d[RMW]};
            end
            for (int s = 1; s < RSTEPS; s++) begin
                n_op[j][s] = {r_op[j][s-1][RW-3:0], 2'b00};
            end
        end
    end

    assign n_s1 = {5'b0, r_qd[NST-2]} + {1'b0, r_rt[0][RSTEPS]};
    assign n_s4 = {r_qd[NST-2][0], 2'b00} + r_rt[1][RSTEPS][2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_v[0] <= i_in_valid;
            for (int k = 1; k < NST; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qd[0] <= i_q;
            for (int k = 1; k < NST - 1; k++) begin
                r_qd[k] <= r_qd[k-1];
            end
            r_aa <= n_aa;
            r_ab <= n_ab;
            r_bb <= n_bb;
            r_sq <= n_sq;
            r_op[0][0]  <= n_n;
            r_op[1][0]  <= {n_n[RW-5:0], 4'b0000};
            for (int j = 0; j < 2; j++) begin
                r_rem[j][0] <= '0;
                r_rt[j][0]  <= '0;
                for (int s = 1; s <= RSTEPS; s++) begin
                    r_rem[j][s] <= n_rem[j][s];
                    r_rt[j][s]  <= n_rt[j][s];
                end
                for (int s = 1; s < RSTEPS; s++) begin
                    r_op[j][s] <= n_op[j][s];
                end
            end
            r_ff <= n_s1[QBITS+1:1];
            r_fd <= n_s4[2:1];
        end
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_out_ready) begin
            r_ov <= r_sv || pv;
            r_sv <= 1'b0;
        end else if (pv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_out_ready) begin
            r_of <= r_sv ? r_sf : r_ff;
            r_od <= r_sv ? r_sd : r_fd;
        end else if (pv) begin
            r_sf <= r_ff;
            r_sd <= r_fd;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_floor_phi_q = r_of;
    assign o_base4_digit = r_od;

    a_skid_only_behind_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a result while the output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && i_out_ready) |=> (o_out_valid && !r_sv))
        else $error("skid result not moved to the output register");

    a_root1_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NST-2] |-> (r_rem[0][RSTEPS] <= {1'b0, r_rt[0][RSTEPS], 1'b0}))
        else $error("first root remainder exceeds twice the root");

    a_root4_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NST-2] |-> (r_rem[1][RSTEPS] <= {1'b0, r_rt[1][RSTEPS], 1'b0}))
        else $error("second root remainder exceeds twice the root");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output valid or stall after reset");

endmodule

/* tb/golden_ratio_floor_digit_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for golden_ratio_floor_digit_unit: floor(q*phi) and the base-4 digit.
// Predicts each transaction with 128-bit integer square roots and checks results in order.
// Depends on gfd_pkg and the unit's RTL.
module golden_ratio_floor_digit_unit_tb;

    localparam int unsigned QBITS        = gfd_pkg::DEF_QBITS;
    localparam int unsigned LATENCY      = QBITS + 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1550;

    typedef struct packed {
        logic [QBITS:0] floor_q;
        logic [1:0]     digit;
    } t_golden_result;

    class golden_scoreboard;
        t_golden_result pending[$];
        int unsigned    errors;
        int unsigned    checked;
        int unsigned    digit_seen[4];

        function logic [63:0] isqrt128(logic [127:0] n);
            logic [127:0] rem;
            logic [127:0] root;
            logic [127:0] bitv;
            logic [127:0] trial;
            int           i;
            rem  = n;
            root = '0;
            bitv = 128'b1 << 126;
            for (i = 0; i < 64; i++) begin
                trial = root + bitv;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root[63:0];
        endfunction

        // floor(v*phi) = (v + isqrt(5*v*v)) / 2, v below 2^62
        function logic [63:0] phi_floor(logic [63:0] v);
            logic [127:0] sq;
            logic [64:0]  total;
            sq    = 128'(v) * 128'(v);
            total = 65'(v) + 65'(isqrt128(sq * 128'd5));
            return total[64:1];
        endfunction

        function void note_operand(logic [QBITS-1:0] q);
            logic [63:0]    f1;
            logic [63:0]    f4;
            logic [63:0]    spread;
            t_golden_result exp_res;
            f1              = phi_floor(64'(q));
            f4              = phi_floor(64'(q) << 2);
            spread          = f4 - (f1 << 2);
            exp_res.floor_q = f1[QBITS:0];
            exp_res.digit   = spread[1:0];
            pending         = {pending, exp_res};
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [QBITS:0] floor_q, logic [1:0] digit);
            t_golden_result exp_res;
            if (pending.size() == 0) begin
                report($sformatf("unexpected transaction floor=%0d digit=%0d", floor_q, digit));
            end else begin
                exp_res = pending.pop_front();
                checked++;
                digit_seen[exp_res.digit]++;
                if (floor_q !== exp_res.floor_q)
                    report($sformatf("floor_phi_q got %0d, want %0d", floor_q, exp_res.floor_q));
                if (digit !== exp_res.digit)
                    report($sformatf("base4_digit got %0d, want %0d", digit, exp_res.digit));
            end
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [QBITS-1:0] i_q;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [QBITS:0]   o_floor_phi_q;
    logic [1:0]       o_base4_digit;

    golden_scoreboard sb = new();
    int unsigned      send_idle = 29;
    int unsigned      recv_idle = 79;
    int unsigned      cycles = 0;
    logic [63:0]      fib[0:92];
    int unsigned      fib_top;
    int unsigned      directed_count;

    golden_ratio_floor_digit_unit #(.QBITS(QBITS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_q           (i_q),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_floor_phi_q (o_floor_phi_q),
        .o_base4_digit (o_base4_digit)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_floor_phi_q, o_base4_digit);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     sb.pending.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_operand(input logic [QBITS-1:0] v);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_q        <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_operand(v);
    endtask

    function automatic logic [QBITS-1:0] random_operand();
        logic [63:0] raw;
        int unsigned kind;
        raw  = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        case (kind)
            5, 6: raw = raw >> $urandom_range(0, QBITS - 1);
            7:    raw = fib[$urandom_range(1, fib_top)] + 64'($urandom_range(0, 4)) - 64'd2;
            8:    raw = {64{1'b1}} - 64'($urandom_range(0, 255));
            9:    raw = (64'd1 << $urandom_range(0, QBITS - 1)) + 64'($urandom_range(0, 2)) - 64'd1;
            default: ;
        endcase
        return raw[QBITS-1:0];
    endfunction

    initial begin
        logic [QBITS-1:0] directed[$];
        int               n;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_q        <= '0;
        i_out_ready <= 1'b0;

        fib[0] = 64'd0;
        fib[1] = 64'd1;
        fib_top = 1;
        for (n = 2; n <= 92; n++) begin
            fib[n] = fib[n-1] + fib[n-2];
            if (fib[n] < (64'd1 << QBITS))
                fib_top = n;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{'0, 1, 2, 3, 4, 5, '1, {1'b1, {(QBITS-1){1'b0}}},
                     {1'b0, {(QBITS-1){1'b1}}}, {(QBITS/2){2'b01}}, {(QBITS/2){2'b10}},
                     QBITS'(fib[40]), QBITS'(fib[41]), QBITS'(fib[fib_top - 1]),
                     QBITS'(fib[fib_top]), QBITS'(fib[fib_top] - 64'd1),
                     QBITS'(fib[fib_top] + 64'd1), QBITS'(64'd1 << 32),
                     QBITS'((64'd1 << 32) - 64'd1), QBITS'(64'd1000000007)};
        directed_count = directed.size();
        foreach (directed[k])
            send_operand(directed[k]);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle = 79;
                recv_idle = 29;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            send_operand(random_operand());
        end
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Checked %0d transactions: %0d edge operands, %0d random over three stall mixes",
                 sb.checked, directed_count, RANDOM_ITEMS);
        $display("Digits seen 0/1/2/3: %0d/%0d/%0d/%0d, mismatches %0d", sb.digit_seen[0],
                 sb.digit_seen[1], sb.digit_seen[2], sb.digit_seen[3], sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
